>>> rtl/core/wpm_pkg.sv
// ----------------------------------------------------------------------------
// wpm_pkg
// Shared constants and types for the wildcard pattern matcher core.
// ----------------------------------------------------------------------------
package wpm_pkg;

  // pattern store geometry
  localparam int PATTERN_DEPTH = 64;
  localparam int ADDR_W        = $clog2(PATTERN_DEPTH);
  localparam int LEN_W         = $clog2(PATTERN_DEPTH + 1);
  localparam int SYM_W         = 16;
  localparam int REQ_W         = 2;

  // request codes
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SUBJ   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_END    = 2'd3;

  // pattern metacharacters
  localparam logic [SYM_W-1:0] CH_STAR   = 16'h002A;
  localparam logic [SYM_W-1:0] CH_QUEST  = 16'h003F;
  localparam logic [SYM_W-1:0] CH_LBRACK = 16'h005B;
  localparam logic [SYM_W-1:0] CH_RBRACK = 16'h005D;
  localparam logic [SYM_W-1:0] CH_BANG   = 16'h0021;
  localparam logic [SYM_W-1:0] CH_DASH   = 16'h002D;
  localparam logic [SYM_W-1:0] CH_HASH   = 16'h0023;
  localparam logic [SYM_W-1:0] CH_ZERO   = 16'h0030;
  localparam logic [SYM_W-1:0] CH_NINE   = 16'h0039;

  // control from the sequencer to the position walker
  typedef struct packed {
    logic             start;     // subject walk begins
    logic             step;      // one pattern position is presented
    logic             elem_ok;   // position lies inside the effective pattern
    logic             at_end;    // position equals effective length
    logic             load;      // restart the active set
    logic [LEN_W-1:0] load_lead; // leading star count for restart
    logic             load_fin;  // active bit at effective length after restart
  } walk_ctl_t;

endpackage

>>> rtl/core/wpm_ifs.sv
// ----------------------------------------------------------------------------
// wpm_ifs
// Request and result channels of the wildcard pattern matcher.
// ----------------------------------------------------------------------------
interface wpm_req_if;
  logic                         valid;
  logic                         ready;
  logic [wpm_pkg::REQ_W-1:0]    req_type;
  logic [wpm_pkg::SYM_W-1:0]    symbol;

  modport source (output valid, output req_type, output symbol, input ready);
  modport sink   (input valid, input req_type, input symbol, output ready);
endinterface

interface wpm_res_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_overflow;

  modport source (output valid, output matched, output pattern_overflow, input ready);
  modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

>>> rtl/core/wpm_ram.sv
// ----------------------------------------------------------------------------
// wpm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wpm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/wpm_walker.sv
// ----------------------------------------------------------------------------
// wpm_walker
// Active-position shift line and set evaluator; one pattern position a step.
// ----------------------------------------------------------------------------
module wpm_walker (
  input  logic                          clk,
  input  logic                          rst,
  input  wpm_pkg::walk_ctl_t            ctl,
  input  logic [wpm_pkg::SYM_W-1:0]     elem,
  input  logic [wpm_pkg::SYM_W-1:0]     subj,
  output logic                          fin
);

  localparam int NPOS = wpm_pkg::PATTERN_DEPTH + 1;

  logic [NPOS-1:0]            act_sr;
  logic [NPOS-1:0]            restart_mask;
  logic                       pend;
  logic                       in_set;
  logic                       first;
  logic                       neg;
  logic                       hit;
  logic                       done;
  logic                       dpend;
  logic [wpm_pkg::SYM_W-1:0]  low;

  logic                       self_hit;
  logic                       pend_next;
  logic                       nxt_bit;
  logic                       in_set_next;
  logic                       first_next;
  logic                       neg_next;
  logic                       hit_next;
  logic                       done_next;
  logic                       dpend_next;
  logic [wpm_pkg::SYM_W-1:0]  low_next;
  logic                       elem_hit;
  logic                       set_bad;

  // restart vector: start position plus the run of leading stars
  always_comb begin
    for (int b = 0; b < NPOS; b++) begin
      restart_mask[b] = (b <= int'(ctl.load_lead));
    end
  end

  // per-position transition
  always_comb begin
    self_hit    = 1'b0;
    pend_next   = 1'b0;
    in_set_next = in_set;
    first_next  = first;
    neg_next    = neg;
    hit_next    = hit;
    done_next   = done;
    dpend_next  = dpend;
    low_next    = low;
    elem_hit    = 1'b0;
    set_bad     = 1'b0;
    if (ctl.elem_ok) begin
      if (in_set) begin
        if (first && elem == wpm_pkg::CH_BANG) begin
          neg_next   = 1'b1;
          first_next = 1'b0;
        end else if (elem == wpm_pkg::CH_RBRACK) begin
          // closing bracket: a dangling range is a syntax error
          set_bad     = dpend && !done;
          pend_next   = neg ? (!hit && !set_bad) : hit;
          in_set_next = 1'b0;
          first_next  = 1'b0;
        end else begin
          first_next = 1'b0;
          if (!done) begin
            elem_hit = (dpend && subj >= low && subj <= elem) ||
                       (dpend && subj == elem) ||
                       (elem != wpm_pkg::CH_DASH && subj == elem);
            low_next   = (dpend || elem != wpm_pkg::CH_DASH) ? elem : low;
            dpend_next = (elem == wpm_pkg::CH_DASH);
            if (elem_hit) begin
              hit_next  = 1'b1;
              done_next = 1'b1;
            end
          end
        end
      end else if (act_sr[0]) begin
        case (elem)
          wpm_pkg::CH_STAR:  self_hit  = 1'b1;
          wpm_pkg::CH_QUEST: pend_next = 1'b1;
          wpm_pkg::CH_HASH:  pend_next = (subj >= wpm_pkg::CH_ZERO) &&
                                         (subj <= wpm_pkg::CH_NINE);
          wpm_pkg::CH_LBRACK: begin
            in_set_next = 1'b1;
            first_next  = 1'b1;
            neg_next    = 1'b0;
            hit_next    = 1'b0;
            done_next   = 1'b0;
            dpend_next  = 1'b0;
            low_next    = '0;
          end
          default:           pend_next = (subj == elem);
        endcase
      end
    end
    nxt_bit = pend | self_hit;
    // a star may match nothing: pass activity on
    if (ctl.elem_ok && elem == wpm_pkg::CH_STAR && nxt_bit) begin
      pend_next = 1'b1;
    end
  end

  // control state of the walk
  always_ff @(posedge clk) begin
    if (rst) begin
      pend   <= 1'b0;
      in_set <= 1'b0;
    end else if (ctl.start) begin
      pend   <= 1'b0;
      in_set <= 1'b0;
    end else if (ctl.step) begin
      pend   <= pend_next;
      in_set <= in_set_next;
    end
  end

  // set evaluator context
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      first <= first_next;
      neg   <= neg_next;
      hit   <= hit_next;
      done  <= done_next;
      dpend <= dpend_next;
      low   <= low_next;
    end
  end

  // active line rotates once per walk; new bits enter at the top
  always_ff @(posedge clk) begin
    if (rst) begin
      act_sr <= {{(NPOS-1){1'b0}}, 1'b1};
      fin    <= 1'b1;
    end else if (ctl.load) begin
      act_sr <= restart_mask;
      fin    <= ctl.load_fin;
    end else if (ctl.step) begin
      act_sr <= {nxt_bit, act_sr[NPOS-1:1]};
      if (ctl.at_end) begin
        fin <= nxt_bit;
      end
    end
  end

endmodule

>>> rtl/core/wildcard_pattern_matcher_core.sv
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher_core
// Wildcard pattern store and streaming subject matcher.
//
//   channel  dir  fields                        result
//   in       in   req_type, symbol              clear, append, subject, end
//   out      out  matched, pattern_overflow     one transfer per end request
//
// A subject character walks all PATTERN_DEPTH+1 positions, one per cycle,
// through the pattern RAM read port.
// Clear, append and end each take a request and then an active-set restart.
// Reset leaves an empty pattern and the start position active.
// An end request waits while an earlier result is still held on out.
// ----------------------------------------------------------------------------
module wildcard_pattern_matcher_core (
  input  logic      clk,
  input  logic      rst,
  wpm_req_if.sink   in,
  wpm_res_if.source out
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic                              state;
  logic [wpm_pkg::LEN_W-1:0]         plen;
  logic [wpm_pkg::LEN_W-1:0]         elen;
  logic [wpm_pkg::LEN_W-1:0]         lead;
  logic                              zseen;
  logic                              lrun;
  logic                              ovf;
  logic                              load_pend;
  logic [wpm_pkg::LEN_W-1:0]         idx;
  logic [wpm_pkg::LEN_W-1:0]         pidx;
  logic                              pv;
  logic [wpm_pkg::SYM_W-1:0]         subj;
  logic                              o_valid;
  logic                              o_matched;
  logic                              o_ovf;

  logic                              acc;
  logic                              full;
  logic                              ram_we;
  logic [wpm_pkg::SYM_W-1:0]         rdata;
  logic                              fin;
  logic                              walk_done;
  wpm_pkg::walk_ctl_t                ctl;

  // input handshake
  assign full     = (plen == wpm_pkg::LEN_W'(wpm_pkg::PATTERN_DEPTH));
  assign in.ready = (state == ST_IDLE) && !load_pend &&
                    !(in.req_type == wpm_pkg::REQ_END && o_valid && !out.ready);
  assign acc      = in.valid && in.ready;
  assign ram_we   = acc && in.req_type == wpm_pkg::REQ_APPEND && !full;
  assign walk_done = pv && (pidx == wpm_pkg::LEN_W'(wpm_pkg::PATTERN_DEPTH));

  // pattern store
  wpm_ram #(
    .WIDTH (wpm_pkg::SYM_W),
    .DEPTH (wpm_pkg::PATTERN_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (plen[wpm_pkg::ADDR_W-1:0]),
    .wdata (in.symbol),
    .raddr (idx[wpm_pkg::ADDR_W-1:0]),
    .rdata (rdata)
  );

  // walker control
  always_comb begin
    ctl.start     = acc && in.req_type == wpm_pkg::REQ_SUBJ;
    ctl.step      = pv;
    ctl.elem_ok   = pv && (pidx < elen);
    ctl.at_end    = pidx == elen;
    ctl.load      = load_pend;
    ctl.load_lead = lead;
    ctl.load_fin  = (lead == elen);
  end

  wpm_walker u_walker (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .elem (rdata),
    .subj (subj),
    .fin  (fin)
  );

  // pattern bookkeeping and sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      plen      <= '0;
      elen      <= '0;
      lead      <= '0;
      zseen     <= 1'b0;
      lrun      <= 1'b1;
      ovf       <= 1'b0;
      load_pend <= 1'b0;
      pv        <= 1'b0;
      idx       <= '0;
    end else begin
      load_pend <= acc && in.req_type != wpm_pkg::REQ_SUBJ;
      if (acc) begin
        case (in.req_type)
          wpm_pkg::REQ_CLEAR: begin
            plen  <= '0;
            elen  <= '0;
            lead  <= '0;
            zseen <= 1'b0;
            lrun  <= 1'b1;
            ovf   <= 1'b0;
          end
          wpm_pkg::REQ_APPEND: begin
            if (full) begin
              ovf <= 1'b1;
            end else begin
              plen <= plen + 1'b1;
              if (!zseen) begin
                if (in.symbol == '0) begin
                  zseen <= 1'b1;
                end else begin
                  elen <= elen + 1'b1;
                  if (lrun && in.symbol == wpm_pkg::CH_STAR) begin
                    lead <= lead + 1'b1;
                  end else begin
                    lrun <= 1'b0;
                  end
                end
              end
            end
          end
          wpm_pkg::REQ_SUBJ: begin
            state <= ST_WALK;
            idx   <= '0;
            pv    <= 1'b0;
          end
          default: ;
        endcase
      end else if (state == ST_WALK) begin
        idx  <= idx + 1'b1;
        pv   <= 1'b1;
        if (walk_done) begin
          state <= ST_IDLE;
          pv    <= 1'b0;
        end
      end
    end
  end

  // position and subject registers
  always_ff @(posedge clk) begin
    pidx <= idx;
    if (ctl.start) begin
      subj <= in.symbol;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (acc && in.req_type == wpm_pkg::REQ_END) begin
      o_valid <= 1'b1;
    end else if (out.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && in.req_type == wpm_pkg::REQ_END) begin
      o_matched <= fin && !ovf;
      o_ovf     <= ovf;
    end
  end

  assign out.valid            = o_valid;
  assign out.matched          = o_matched;
  assign out.pattern_overflow = o_ovf;

  // checks
  a_elen_le_plen: assert property (@(posedge clk) disable iff (rst)
    elen <= plen) else $error("effective length beyond stored length");

  a_lead_le_elen: assert property (@(posedge clk) disable iff (rst)
    lead <= elen) else $error("leading star run beyond effective length");

  a_walk_blocks: assert property (@(posedge clk) disable iff (rst)
    state == ST_WALK |-> !in.ready) else $error("request taken during walk");

  a_walk_ends: assert property (@(posedge clk) disable iff (rst)
    walk_done |=> state == ST_IDLE) else $error("walk did not finish");

endmodule

>>> test/wildcard_pattern_matcher_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher_core_test
// Streams pattern builds and subject strings into the matcher, predicts each
// end-of-subject verdict with an active-position model of the glob rules and
// compares every result transfer against it, with random gaps on both sides.
// ----------------------------------------------------------------------------
module wildcard_pattern_matcher_core_test;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } verdict_t;

  // active-position model of the glob matcher plus its pending verdicts
  class glob_predictor;
    logic [wpm_pkg::SYM_W-1:0] pat[wpm_pkg::PATTERN_DEPTH];
    int                        pat_len;
    bit                        live[wpm_pkg::PATTERN_DEPTH+1];
    bit                        ovf;
    verdict_t                  verdicts[$];
    int                        errors;

    function new();
      pat_len = 0;
      ovf     = 1'b0;
      errors  = 0;
      restart();
    endfunction

    function int used_len();
      int n;
      n = 0;
      while (n < pat_len && pat[n] != 16'h0000) n++;
      return n;
    endfunction

    // a star may match nothing, so activity falls through it
    function void spread(int n);
      for (int i = 0; i < n; i++)
        if (live[i] && pat[i] == wpm_pkg::CH_STAR) live[i+1] = 1'b1;
    endfunction

    function void restart();
      foreach (live[i]) live[i] = 1'b0;
      live[0] = 1'b1;
      spread(used_len());
    endfunction

    // returns position after ']' on a hit, -1 otherwise
    function int set_hit(int i, int n, logic [wpm_pkg::SYM_W-1:0] c);
      int j, k;
      logic [wpm_pkg::SYM_W-1:0] lo, p;
      bit neg, hit, bad;
      j = i + 1; lo = '0; neg = 1'b0; hit = 1'b0; bad = 1'b0;
      if (j < n && pat[j] == wpm_pkg::CH_BANG) begin
        neg = 1'b1;
        j++;
      end
      k = j;
      while (k < n && pat[k] != wpm_pkg::CH_RBRACK) k++;
      if (k >= n) return -1;
      for (int q = j; q < k; q++) begin
        p = pat[q];
        if (p == wpm_pkg::CH_DASH) begin
          if (q + 1 >= k) begin
            bad = 1'b1;
            break;
          end
          p = pat[q+1];
          if (c >= lo && c <= p) begin
            hit = 1'b1;
            break;
          end
        end
        lo = p;
        if (c == p) begin
          hit = 1'b1;
          break;
        end
      end
      if (neg ? (!hit && !bad) : hit) return k + 1;
      return -1;
    endfunction

    function void advance(logic [wpm_pkg::SYM_W-1:0] c);
      bit nxt[wpm_pkg::PATTERN_DEPTH+1];
      int n, to;
      n = used_len();
      foreach (nxt[i]) nxt[i] = 1'b0;
      for (int i = 0; i < n; i++) begin
        if (live[i]) begin
          if (pat[i] == wpm_pkg::CH_STAR) nxt[i] = 1'b1;
          else if (pat[i] == wpm_pkg::CH_QUEST) nxt[i+1] = 1'b1;
          else if (pat[i] == wpm_pkg::CH_HASH) begin
            if (c >= wpm_pkg::CH_ZERO && c <= wpm_pkg::CH_NINE) nxt[i+1] = 1'b1;
          end else if (pat[i] == wpm_pkg::CH_LBRACK) begin
            to = set_hit(i, n, c);
            if (to >= 0 && to <= n) nxt[to] = 1'b1;
          end else if (c == pat[i]) nxt[i+1] = 1'b1;
        end
      end
      live = nxt;
      spread(n);
    endfunction

    function void note_request(logic [wpm_pkg::REQ_W-1:0] kind,
                               logic [wpm_pkg::SYM_W-1:0] sym);
      verdict_t v;
      case (kind)
        wpm_pkg::REQ_CLEAR: begin
          pat_len = 0;
          ovf     = 1'b0;
          restart();
        end
        wpm_pkg::REQ_APPEND: begin
          if (pat_len < wpm_pkg::PATTERN_DEPTH) begin
            pat[pat_len] = sym;
            pat_len++;
          end else ovf = 1'b1;
          restart();
        end
        wpm_pkg::REQ_SUBJ: advance(sym);
        default: begin
          v.matched          = live[used_len()] && !ovf;
          v.pattern_overflow = ovf;
          verdicts.push_back(v);
          restart();
        end
      endcase
    endfunction

    function void check_result(logic m, logic o);
      verdict_t v;
      if (verdicts.size() == 0) begin
        $display("%0t: unexpected result expected none actual matched=%0b overflow=%0b",
                 $time, m, o);
        errors++;
        return;
      end
      v = verdicts.pop_front();
      if (m !== v.matched) begin
        $display("%0t: matched expected %0b actual %0b", $time, v.matched, m);
        errors++;
      end
      if (o !== v.pattern_overflow) begin
        $display("%0t: pattern_overflow expected %0b actual %0b",
                 $time, v.pattern_overflow, o);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   calm_phase;
  int   sent;
  glob_predictor model;

  wpm_req_if req_ch();
  wpm_res_if res_ch();

  wildcard_pattern_matcher_core dut (
    .clk (clk),
    .rst (rst),
    .in  (req_ch),
    .out (res_ch)
  );

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function int pick_gap();
    return calm_phase ? 0 : $urandom_range(0, 4);
  endfunction

  function logic [wpm_pkg::SYM_W-1:0] rand_sym();
    return wpm_pkg::SYM_W'($urandom);
  endfunction

  // one request transfer, valid held across back-to-back items
  task send(logic [wpm_pkg::REQ_W-1:0] kind, logic [wpm_pkg::SYM_W-1:0] sym);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.symbol   <= sym;
    do @(posedge clk); while (!req_ch.ready);
    model.note_request(kind, sym);
    sent++;
  endtask

  task send_text(logic [wpm_pkg::REQ_W-1:0] kind, string s);
    for (int i = 0; i < s.len(); i++) send(kind, {8'h00, s[i]});
  endtask

  // pattern build from text, then subject + end
  task set_pattern(string s);
    send(wpm_pkg::REQ_CLEAR, rand_sym());
    send_text(wpm_pkg::REQ_APPEND, s);
  endtask

  task try_subject(string s);
    send_text(wpm_pkg::REQ_SUBJ, s);
    send(wpm_pkg::REQ_END, rand_sym());
  endtask

  function logic [wpm_pkg::SYM_W-1:0] pick_sym(bit in_pattern);
    int r;
    r = $urandom_range(0, 39);
    if (r == 0) return 16'h0000;
    if (r < 3) return rand_sym();
    if (r < 5) return {$urandom_range(0, 1) ? 8'hFF : 8'h00, 8'h61};
    if (in_pattern) begin
      case (r % 9)
        0: return wpm_pkg::CH_STAR;
        1: return wpm_pkg::CH_QUEST;
        2: return wpm_pkg::CH_HASH;
        3: return wpm_pkg::CH_LBRACK;
        4: return wpm_pkg::CH_RBRACK;
        5: return wpm_pkg::CH_BANG;
        6: return wpm_pkg::CH_DASH;
        default: ;
      endcase
    end
    if (r % 3 == 0) return wpm_pkg::CH_ZERO + wpm_pkg::SYM_W'($urandom_range(0, 9));
    return 16'h0061 + wpm_pkg::SYM_W'($urandom_range(0, 3));
  endfunction

  // result side: random stalls, check on every transfer
  initial begin
    int gap;
    res_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      model.check_result(res_ch.matched, res_ch.pattern_overflow);
    end
  end

  // stimulus
  initial begin
    int plen, wait_cycles;
    model           = new();
    sent            = 0;
    calm_phase      = 1'b0;
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.req_type = wpm_pkg::REQ_CLEAR;
    req_ch.symbol   = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: metacharacters, sets, ranges and corner cases
    try_subject("");
    set_pattern("a*[b-d]?#[!x]");
    try_subject("azc90y");
    try_subject("ab10x");
    set_pattern("[a-]");
    try_subject("a");
    set_pattern("[-c][]");
    try_subject("b");
    set_pattern("[!][");
    try_subject("q");
    send(wpm_pkg::REQ_APPEND, 16'hFFFF);
    send(wpm_pkg::REQ_APPEND, 16'h0000);
    send(wpm_pkg::REQ_APPEND, wpm_pkg::CH_STAR);
    send(wpm_pkg::REQ_SUBJ, 16'h0000);
    try_subject("");

    // random pattern groups, each tried with one to five subjects
    while (sent < 1500) begin
      calm_phase = ($urandom_range(0, 3) == 0);
      send(wpm_pkg::REQ_CLEAR, rand_sym());
      plen = ($urandom_range(0, 24) == 0) ? $urandom_range(60, 70)
                                         : $urandom_range(0, 8);
      for (int i = 0; i < plen; i++) send(wpm_pkg::REQ_APPEND, pick_sym(1'b1));
      repeat ($urandom_range(1, 5)) begin
        repeat ($urandom_range(0, 7)) send(wpm_pkg::REQ_SUBJ, pick_sym(1'b0));
        send(wpm_pkg::REQ_END, rand_sym());
      end
    end
    req_ch.valid <= 1'b0;

    wait_cycles = 0;
    while (model.verdicts.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (200) @(posedge clk);
    if (model.errors == 0 && model.verdicts.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> files.f
rtl/core/wpm_pkg.sv
rtl/core/wpm_ifs.sv
rtl/core/wpm_ram.sv
rtl/core/wpm_walker.sv
rtl/core/wildcard_pattern_matcher_core.sv
test/wildcard_pattern_matcher_core_test.sv
